// ===== src/jpeg_bit_writer_with_stuffing_defines.svh =====
// ----------------------------------------------------------------------------
// JPEG bit writer assertion macros
// Shared macros for the concurrent checks of the bit writer.
// ----------------------------------------------------------------------------
`ifndef JPEG_BIT_WRITER_WITH_STUFFING_DEFINES_SVH
`define JPEG_BIT_WRITER_WITH_STUFFING_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define JBWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define JBWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked through reset.
`define JBWS_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/jbws_pkg.sv =====
// ----------------------------------------------------------------------------
// JPEG bit writer package
// Types and constants shared by the front end, the job queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package jbws_pkg;

    // Marker and stuffing byte values.
    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_D9   = 8'hD9;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    // Field widths.
    localparam int CODE_W   = 16;
    localparam int LEN_W    = 5;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W = 3;

    // Longest code that is appended.
    localparam logic [LEN_W-1:0] MAX_LEN = 5'd16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SAME_CODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAME_LEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B2W_CODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B2W_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_W2B_CODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_W2B_LEN   = 3'd5;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_RAW    = 2'd0,
        CMD_MODULE = 2'd1,
        CMD_BLANK  = 2'd2,
        CMD_FINISH = 2'd3
    } t_cmd;

    // Job queue depth and derived widths.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One job: up to three bytes in stream order, with a stuffing flag.
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] nb;     // number of bytes, 1 to 3
        logic       stuff;  // follow each 0xFF with a 0x00
    } t_job;

    // Queue status seen by the front and back ends.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

`default_nettype wire

// ===== src/jbws_front.sv =====
// ----------------------------------------------------------------------------
// JPEG bit writer front end
// Holds the configuration and the leftover bits, turns each item that yields bytes into a job.
// ----------------------------------------------------------------------------
`default_nettype none

module jbws_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [jbws_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [jbws_pkg::CODE_W-1:0]    i_cfg_data,
    input  wire logic                           i_accept,
    input  wire logic [jbws_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [jbws_pkg::CODE_W-1:0]    i_code_value,
    input  wire logic [jbws_pkg::LEN_W-1:0]     i_code_length,
    input  wire logic                           i_module_black,
    input  wire logic                           i_row_start,
    output      logic                           o_push,
    output      jbws_pkg::t_job                 o_job
);
    import jbws_pkg::*;

    logic [CODE_W-1:0] r_same_code, r_b2w_code, r_w2b_code;
    logic [LEN_W-1:0]  r_same_len, r_b2w_len, r_w2b_len;
    logic [6:0]        r_acc, n_acc;
    logic [2:0]        r_cnt, n_cnt;
    logic              r_prev, n_prev;

    t_cmd              cmd;
    logic              prev_eff;
    logic [CODE_W-1:0] sel_code;
    logic [LEN_W-1:0]  sel_len_raw;
    logic [LEN_W-1:0]  sel_len;
    logic [16:0]       mask;
    logic [CODE_W-1:0] masked;
    logic [23:0]       hi_bits;
    logic [23:0]       code_bits;
    logic [23:0]       word;
    logic [LEN_W-1:0]  total;
    logic [1:0]        app_nb;
    logic [23:0]       left_bits;
    logic [7:0]        pad_byte;

    // Configuration registers, to be written by the user only while the block is idle; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_same_code <= '0;
            r_same_len  <= LEN_W'(1);
            r_b2w_code  <= '0;
            r_b2w_len   <= LEN_W'(1);
            r_w2b_code  <= '0;
            r_w2b_len   <= LEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SAME_CODE: r_same_code <= i_cfg_data;
                CFG_SAME_LEN:  r_same_len  <= i_cfg_data[LEN_W-1:0];
                CFG_B2W_CODE:  r_b2w_code  <= i_cfg_data;
                CFG_B2W_LEN:   r_b2w_len   <= i_cfg_data[LEN_W-1:0];
                CFG_W2B_CODE:  r_w2b_code  <= i_cfg_data;
                CFG_W2B_LEN:   r_w2b_len   <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Pick the code for the command; a row start takes the previous module as white.
    always_comb begin
        cmd         = t_cmd'(i_cmd);
        prev_eff    = i_row_start ? 1'b0 : r_prev;
        sel_code    = i_code_value;
        sel_len_raw = i_code_length;
        unique case (cmd)
            CMD_RAW: begin
                sel_code    = i_code_value;
                sel_len_raw = i_code_length;
            end
            CMD_MODULE: begin
                if (prev_eff == i_module_black) begin
                    sel_code    = r_same_code;
                    sel_len_raw = r_same_len;
                end else if (prev_eff) begin
                    sel_code    = r_b2w_code;
                    sel_len_raw = r_b2w_len;
                end else begin
                    sel_code    = r_w2b_code;
                    sel_len_raw = r_w2b_len;
                end
            end
            CMD_BLANK: begin
                sel_code    = r_same_code;
                sel_len_raw = r_same_len;
            end
            CMD_FINISH: begin
                sel_code    = '0;
                sel_len_raw = '0;
            end
            default: ;
        endcase
        sel_len = (sel_len_raw > MAX_LEN) ? MAX_LEN : sel_len_raw;
    end

    // Merge the held bits and the code into one MSB-aligned 24-bit word.
    always_comb begin
        mask      = (17'd1 << sel_len) - 17'd1;
        masked    = sel_code & mask[CODE_W-1:0];
        hi_bits   = {r_acc, 17'b0} << (3'd7 - r_cnt);
        code_bits = ({masked, 8'b0} << (MAX_LEN - sel_len)) >> r_cnt;
        word      = hi_bits | code_bits;
        total     = {2'b00, r_cnt} + sel_len;
        app_nb    = total[4:3];
        left_bits = word << {app_nb, 3'b000};
        pad_byte  = hi_bits[23:16] | (8'hFF >> r_cnt);
    end

    // Next state and the job for this item.
    always_comb begin
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_prev = r_prev;
        o_job  = '{b0: word[23:16], b1: word[15:8], b2: BYTE_ZERO,
                   nb: app_nb, stuff: (cmd != CMD_BLANK)};
        if (cmd == CMD_FINISH) begin
            n_acc = '0;
            n_cnt = '0;
            if (r_cnt != 3'd0) begin
                o_job = '{b0: pad_byte, b1: BYTE_FF, b2: BYTE_D9, nb: 2'd3, stuff: 1'b0};
            end else begin
                o_job = '{b0: BYTE_FF, b1: BYTE_D9, b2: BYTE_ZERO, nb: 2'd2, stuff: 1'b0};
            end
        end else begin
            n_cnt = total[2:0];
            n_acc = left_bits[23:17] >> (3'd7 - total[2:0]);
            if (cmd == CMD_MODULE) begin
                n_prev = i_module_black;
            end
        end
        o_push = i_accept && (o_job.nb != 2'd0);
    end

    // Leftover bits and the previous module colour.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_cnt  <= '0;
            r_prev <= 1'b0;
        end else if (i_accept) begin
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
            r_prev <= n_prev;
        end
    end

endmodule

`default_nettype wire

// ===== src/jbws_queue.sv =====
// ----------------------------------------------------------------------------
// JPEG bit writer job queue
// Short FIFO of jobs between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module jbws_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire jbws_pkg::t_job i_job,
    input  wire logic    i_pop,
    output jbws_pkg::t_job o_head,
    output jbws_pkg::t_q_stat o_stat
);
    import jbws_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_stat.empty = (r_count == QCNT_W'(0));
    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rptr];

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/jbws_back.sv =====
// ----------------------------------------------------------------------------
// JPEG bit writer back end
// Walks the bytes of the head job, inserts stuffed zeros, drives the output.
// ----------------------------------------------------------------------------
`default_nettype none

module jbws_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire jbws_pkg::t_job    i_head,
    input  wire jbws_pkg::t_q_stat i_stat,
    output      logic        o_pop,
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic [7:0]  o_out_byte,
    output      logic        o_last
);
    import jbws_pkg::*;

    logic [1:0] r_idx;
    logic       r_stuff;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    logic [7:0] cur_byte;
    logic       do_stuff;
    logic       end_byte;
    logic       emit;

    // Current byte of the head job.
    always_comb begin
        case (r_idx)
            2'd0:    cur_byte = i_head.b0;
            2'd1:    cur_byte = i_head.b1;
            default: cur_byte = i_head.b2;
        endcase
        do_stuff = i_head.stuff && (cur_byte == BYTE_FF) && !r_stuff;
        end_byte = (r_idx == (i_head.nb - 2'd1));
        emit     = !i_stat.empty && (!r_valid || !i_out_stall);
        o_pop    = emit && end_byte && !do_stuff;
    end

    // Byte position and pending stuffed zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_stuff <= 1'b0;
        end else if (emit) begin
            if (do_stuff) begin
                r_stuff <= 1'b1;
            end else begin
                r_stuff <= 1'b0;
                r_idx   <= end_byte ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    // Output register; it parts the queue from the consumer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (emit) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= r_stuff ? BYTE_ZERO : cur_byte;
            r_last <= end_byte && !do_stuff;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_last      = r_last;

endmodule

`default_nettype wire

// ===== src/jpeg_bit_writer_with_stuffing.sv =====
// ----------------------------------------------------------------------------
// JPEG bit writer with byte stuffing
// Packs codes MSB-first into scan bytes, stuffs 0xFF of raw and module codes, ends with EOI.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                   Payload
//  in       input      i_in_valid / o_in_stall     cmd, code_value, code_length,
//                                                  module_black, row_start
//  out      output     o_out_valid / i_out_stall   out_byte, last
//  cfg      input      i_cfg_we                    i_cfg_index, i_cfg_data
//
//  An item can be accepted every cycle while the two-entry job queue has room.
//  The byte sequencer sends one byte per cycle unless the output stalls;
//  an item yields zero to four bytes, so the sequencer sets the rate.
//  The first byte of an item passes the job queue, then the output register.
//  Reset is synchronous and active low; it empties the queue and the output.
//  A stall on the output fills the queue, then stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_bit_writer_with_stuffing (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [jbws_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [jbws_pkg::CODE_W-1:0]    i_cfg_data,
    input  wire logic                           i_in_valid,
    output      logic                           o_in_stall,
    input  wire logic [jbws_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [jbws_pkg::CODE_W-1:0]    i_code_value,
    input  wire logic [jbws_pkg::LEN_W-1:0]     i_code_length,
    input  wire logic                           i_module_black,
    input  wire logic                           i_row_start,
    output      logic                           o_out_valid,
    input  wire logic                           i_out_stall,
    output      logic [7:0]                     o_out_byte,
    output      logic                           o_last
);
    import jbws_pkg::*;

    t_job    push_job, head_job;
    t_q_stat q_stat;
    logic    push, pop, accept;

    // Input is taken whenever the queue has room.
    assign o_in_stall = q_stat.full;
    assign accept     = i_in_valid && !q_stat.full;

    jbws_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_cmd          (i_cmd),
        .i_code_value   (i_code_value),
        .i_code_length  (i_code_length),
        .i_module_black (i_module_black),
        .i_row_start    (i_row_start),
        .o_push         (push),
        .o_job          (push_job)
    );

    jbws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (q_stat)
    );

    jbws_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_job),
        .i_stat      (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

// ===== src/jbws_checker.sv =====
// ----------------------------------------------------------------------------
// JPEG bit writer port checker
// Checks port behavior of the bit writer over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "jpeg_bit_writer_with_stuffing_defines.svh"

module jbws_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_last
);

    // A stalled result byte holds.
    `JBWS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_byte) && $stable(o_last), "output byte changed while stalled")

    // The rest of an item's bytes is already queued, so they follow without a gap.
    `JBWS_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_last, o_out_valid, "gap inside the bytes of one item")

    // The queue only fills through an accepted item.
    `JBWS_ASSERT_NOW(a_stall_rise, i_clk, i_rst_n, $rose(o_in_stall), $past(i_in_valid), "input stall rose without an accepted item")

    // Reset leaves an empty output and an open input.
    `JBWS_ASSERT_ALWAYS_NEXT(a_reset, i_clk, !i_rst_n, !o_out_valid && !o_in_stall, "output or stall not cleared by reset")

endmodule

bind jpeg_bit_writer_with_stuffing jbws_checker u_jbws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_byte  (o_out_byte),
    .o_last      (o_last)
);

`default_nettype wire

// ===== tb/sv/jbws_scan_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JPEG scan byte checker
// Watches the register port and both item channels of the bit writer. Keeps
// its own copy of the bit packer, works out the scan bytes that each accepted
// item must cause, and compares every byte that leaves the block with the
// oldest one still owed.
// ----------------------------------------------------------------------------
module jbws_scan_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [jbws_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [jbws_pkg::CODE_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [jbws_pkg::CMD_W-1:0]     i_cmd,
    input  logic [jbws_pkg::CODE_W-1:0]    i_code_value,
    input  logic [jbws_pkg::LEN_W-1:0]     i_code_length,
    input  logic                           i_module_black,
    input  logic                           i_row_start,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [7:0]                     i_out_byte,
    input  logic                           i_last,
    output int                             o_fail_count,
    output int                             o_pending
);
    import jbws_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_scan_byte;

    // Register copies.
    logic [CODE_W-1:0] same_code_q, b2w_code_q, w2b_code_q;
    logic [LEN_W-1:0]  same_len_q, b2w_len_q, w2b_len_q;

    // Packer state: held bits, right aligned, and their count.
    logic [6:0] held_bits;
    logic [2:0] held_cnt;
    logic       prev_black;

    logic [7:0] item_bytes[$];
    t_scan_byte expected_bytes[$];

    // Append the low bits of a code MSB-first, emitting every full byte.
    function automatic void append_code(logic [CODE_W-1:0] value, logic [LEN_W-1:0] length,
                                        logic stuff);
        int unsigned eff_len;
        int unsigned nbits;
        logic [23:0] acc;
        logic [7:0]  b;
        eff_len = (length > MAX_LEN) ? 16 : int'(length);
        if (eff_len == 0) return;
        acc = (24'(held_bits) << eff_len) | (24'(value) & ((24'd1 << eff_len) - 24'd1));
        nbits = int'(held_cnt) + eff_len;
        while (nbits >= 8) begin
            nbits -= 8;
            b = 8'(acc >> nbits);
            item_bytes.push_back(b);
            if (stuff && b == BYTE_FF) item_bytes.push_back(BYTE_ZERO);
        end
        held_bits = 7'(acc & ((24'd1 << nbits) - 24'd1));
        held_cnt  = 3'(nbits);
    endfunction

    // Work out the bytes caused by one item and queue them, the last one marked.
    function automatic void predict_item(t_cmd cmd, logic [CODE_W-1:0] value,
                                         logic [LEN_W-1:0] length, logic black,
                                         logic row_start);
        logic       prev;
        int unsigned pad;
        t_scan_byte entry;
        item_bytes.delete();
        case (cmd)
            CMD_RAW: append_code(value, length, 1'b1);
            CMD_MODULE: begin
                // A row start treats the previous module as white.
                prev = row_start ? 1'b0 : prev_black;
                if (prev == black) append_code(same_code_q, same_len_q, 1'b1);
                else if (prev) append_code(b2w_code_q, b2w_len_q, 1'b1);
                else append_code(w2b_code_q, w2b_len_q, 1'b1);
                prev_black = black;
            end
            CMD_BLANK: append_code(same_code_q, same_len_q, 1'b0);
            CMD_FINISH: begin
                // Pad held bits with ones, unstuffed, then the end marker.
                if (held_cnt != 0) begin
                    pad = 8 - int'(held_cnt);
                    item_bytes.push_back(8'(((int'(held_bits) + 1) << pad) - 1));
                end
                item_bytes.push_back(BYTE_FF);
                item_bytes.push_back(BYTE_D9);
                held_bits = '0;
                held_cnt  = '0;
            end
            default: ;
        endcase
        foreach (item_bytes[k]) begin
            entry.data = item_bytes[k];
            entry.last = (k == item_bytes.size() - 1);
            expected_bytes.push_back(entry);
        end
    endfunction

    // Track registers and items, and check each byte that leaves the block.
    always @(posedge i_clk) begin
        t_scan_byte exp_byte;
        if (!i_rst_n) begin
            same_code_q = '0;
            same_len_q  = 5'd1;
            b2w_code_q  = '0;
            b2w_len_q   = 5'd1;
            w2b_code_q  = '0;
            w2b_len_q   = 5'd1;
            held_bits   = '0;
            held_cnt    = '0;
            prev_black  = 1'b0;
            expected_bytes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SAME_CODE: same_code_q = i_cfg_data;
                    CFG_SAME_LEN:  same_len_q  = i_cfg_data[LEN_W-1:0];
                    CFG_B2W_CODE:  b2w_code_q  = i_cfg_data;
                    CFG_B2W_LEN:   b2w_len_q   = i_cfg_data[LEN_W-1:0];
                    CFG_W2B_CODE:  w2b_code_q  = i_cfg_data;
                    CFG_W2B_LEN:   w2b_len_q   = i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    $error("out_byte %02h arrived with no byte expected", i_out_byte);
                    o_fail_count++;
                end else begin
                    exp_byte = expected_bytes.pop_front();
                    if (i_out_byte !== exp_byte.data) begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               exp_byte.data, i_out_byte);
                        o_fail_count++;
                    end
                    if (i_last !== exp_byte.last) begin
                        $error("last mismatch: expected %0b, actual %0b",
                               exp_byte.last, i_last);
                        o_fail_count++;
                    end
                end
            end

            if (i_in_valid && !i_in_stall)
                predict_item(t_cmd'(i_cmd), i_code_value, i_code_length, i_module_black,
                             i_row_start);
        end
        o_pending <= expected_bytes.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JPEG bit writer testbench
// Drives register settings and command items into the bit writer, with random
// gaps and output stalls, and a checker that predicts the scan bytes. Starts
// with directed items, then random scans of modules, raw codes and blanks that
// end in a finish, mixed with loose items, under several register settings.
// ----------------------------------------------------------------------------
module testbench;
    import jbws_pkg::*;

    localparam int DRAIN_CYCLES     = 12;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int PHASE_ITEMS      = 36;

    // Index with no register behind it; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [CODE_W-1:0]    i_cfg_data     = '0;
    logic                 i_in_valid     = 1'b0;
    logic [CMD_W-1:0]     i_cmd          = '0;
    logic [CODE_W-1:0]    i_code_value   = '0;
    logic [LEN_W-1:0]     i_code_length  = '0;
    logic                 i_module_black = 1'b0;
    logic                 i_row_start    = 1'b0;
    logic                 i_out_stall    = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [7:0]           o_out_byte;
    logic                 o_last;

    int fail_count;
    int pending_bytes;
    int items_sent       = 0;
    int idle_cycles      = 0;
    bit sender_idle_en   = 1'b1;
    bit receiver_idle_en = 1'b1;
    bit hold_request     = 1'b0;

    always #5 i_clk = ~i_clk;

    jpeg_bit_writer_with_stuffing dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_code_value   (i_code_value),
        .i_code_length  (i_code_length),
        .i_module_black (i_module_black),
        .i_row_start    (i_row_start),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_last         (o_last)
    );

    jbws_scan_checker scan_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_code_value   (i_code_value),
        .i_code_length  (i_code_length),
        .i_module_black (i_module_black),
        .i_row_start    (i_row_start),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_byte     (o_out_byte),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending_bytes)
    );

    // Output stalls: random short bursts, or one long hold on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (receiver_idle_en && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Ends the run when nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offer one item and hold it until it is taken, then maybe idle a while.
    task automatic send_item(input t_cmd cmd, input logic [CODE_W-1:0] value,
                             input logic [LEN_W-1:0] length, input logic black,
                             input logic row_start);
        i_in_valid     <= 1'b1;
        i_cmd          <= cmd;
        i_code_value   <= value;
        i_code_length  <= length;
        i_module_black <= black;
        i_row_start    <= row_start;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (sender_idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Stop offering, wait for every owed byte, then let the pipeline settle.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all six registers back to back, then a write to the spare index.
    task automatic load_config(input logic [CODE_W-1:0] s_code, input logic [LEN_W-1:0] s_len,
                               input logic [CODE_W-1:0] b_code, input logic [LEN_W-1:0] b_len,
                               input logic [CODE_W-1:0] w_code, input logic [LEN_W-1:0] w_len);
        logic [CODE_W-1:0]    data_list [6];
        logic [CFG_IDX_W-1:0] index_list [6];
        index_list = '{CFG_SAME_CODE, CFG_SAME_LEN, CFG_B2W_CODE,
                       CFG_B2W_LEN, CFG_W2B_CODE, CFG_W2B_LEN};
        data_list  = '{s_code, CODE_W'(s_len), b_code, CODE_W'(b_len),
                       w_code, CODE_W'(w_len)};
        for (int k = 0; k < 6; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= index_list[k];
            i_cfg_data  <= data_list[k];
            @(posedge i_clk);
        end
        i_cfg_index <= CFG_SPARE;
        i_cfg_data  <= CODE_W'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Code values lean toward all ones and all zeros to hit stuffing often.
    function automatic logic [CODE_W-1:0] pick_code_value();
        case ($urandom_range(0, 4))
            0:       return 16'hFFFF;
            1:       return 16'h0000;
            default: return CODE_W'($urandom);
        endcase
    endfunction

    // Mostly legal lengths, some zero and some oversized.
    function automatic logic [LEN_W-1:0] pick_code_length();
        case ($urandom_range(0, 9))
            0:       return 5'd0;
            1:       return LEN_W'($urandom_range(17, 31));
            default: return LEN_W'($urandom_range(1, 16));
        endcase
    endfunction

    // One scan: rows of modules mixed with raw codes and blanks, then finish.
    task automatic send_scan();
        int n_items;
        int row_len;
        int col;
        int sel;
        n_items = $urandom_range(3, 14);
        row_len = $urandom_range(2, 8);
        col     = 0;
        for (int k = 0; k < n_items; k++) begin
            sel = $urandom_range(0, 9);
            if (sel < 5) begin
                send_item(CMD_MODULE, pick_code_value(), pick_code_length(),
                          1'($urandom_range(0, 1)), col == 0);
                col = (col + 1 == row_len) ? 0 : col + 1;
            end else if (sel < 8) begin
                send_item(CMD_RAW, pick_code_value(), pick_code_length(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                send_item(CMD_BLANK, pick_code_value(), pick_code_length(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
        send_item(CMD_FINISH, pick_code_value(), pick_code_length(),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Mostly whole scans, the rest loose items of any command.
    task automatic run_random_phase(input int n_items);
        int phase_end;
        phase_end = items_sent + n_items;
        while (items_sent < phase_end) begin
            if ($urandom_range(0, 4) != 0)
                send_scan();
            else
                send_item(t_cmd'($urandom_range(0, 3)), pick_code_value(),
                          LEN_W'($urandom), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A few items under the reset register values.
        send_item(CMD_MODULE, 16'h0000, 5'd0, 1'b1, 1'b1);
        send_item(CMD_BLANK, 16'hFFFF, 5'd31, 1'b0, 1'b0);
        send_item(CMD_FINISH, 16'h0000, 5'd0, 1'b0, 1'b0);
        wait_for_drain();

        // Directed items: unchanged code is sixteen ones, so blanks give raw FF.
        load_config(16'hFFFF, 5'd16, 16'h0000, 5'd1, 16'h0005, 5'd3);
        send_item(CMD_RAW, 16'hFFFF, 5'd0, 1'b0, 1'b0);    // appends nothing
        send_item(CMD_RAW, 16'h0001, 5'd1, 1'b0, 1'b0);
        send_item(CMD_RAW, 16'hFFFF, 5'd16, 1'b0, 1'b0);   // two stuffed bytes
        send_item(CMD_RAW, 16'h1234, 5'd31, 1'b1, 1'b1);   // oversized length
        send_item(CMD_MODULE, 16'h0000, 5'd0, 1'b1, 1'b1);  // white to black
        send_item(CMD_MODULE, 16'h0000, 5'd0, 1'b1, 1'b0);  // unchanged black
        send_item(CMD_MODULE, 16'h0000, 5'd0, 1'b0, 1'b0);  // black to white
        send_item(CMD_MODULE, 16'h0000, 5'd0, 1'b0, 1'b0);  // unchanged white
        send_item(CMD_MODULE, 16'h0000, 5'd0, 1'b1, 1'b0);
        send_item(CMD_MODULE, 16'h0000, 5'd0, 1'b0, 1'b1);  // row start, stays white
        send_item(CMD_MODULE, 16'h0000, 5'd0, 1'b1, 1'b0);
        send_item(CMD_MODULE, 16'h0000, 5'd0, 1'b1, 1'b1);  // row start after black
        send_item(CMD_BLANK, 16'h0000, 5'd0, 1'b1, 1'b0);   // FF left unstuffed
        send_item(CMD_RAW, 16'hABCD, 5'd4, 1'b0, 1'b0);    // upper bits ignored
        send_item(CMD_FINISH, 16'h0000, 5'd0, 1'b0, 1'b0);
        send_item(CMD_FINISH, 16'h0000, 5'd0, 1'b0, 1'b0);  // nothing held
        send_item(CMD_RAW, 16'h007F, 5'd7, 1'b0, 1'b0);
        send_item(CMD_FINISH, 16'hFFFF, 5'd16, 1'b1, 1'b1); // pad byte is FF
        send_item(CMD_RAW, 16'h0000, 5'd16, 1'b0, 1'b0);
        send_item(CMD_RAW, 16'hFFFF, 5'd20, 1'b0, 1'b0);
        send_item(CMD_MODULE, 16'h5555, 5'd9, 1'b0, 1'b0);
        send_item(CMD_FINISH, 16'h0000, 5'd0, 1'b0, 1'b0);
        wait_for_drain();

        // Shortest codes, one transition code sixteen ones.
        load_config(16'h0000, 5'd1, 16'h0001, 5'd1, 16'hFFFF, 5'd16);
        run_random_phase(PHASE_ITEMS);
        wait_for_drain();

        // Random codes; the receiver holds off long enough to back up the input.
        load_config(CODE_W'($urandom), LEN_W'($urandom_range(1, 16)),
                    CODE_W'($urandom), LEN_W'($urandom_range(1, 16)),
                    CODE_W'($urandom), LEN_W'($urandom_range(1, 16)));
        hold_request = 1'b1;
        run_random_phase(PHASE_ITEMS);
        wait_for_drain();

        // Zero and oversized register lengths; the sender never idles here.
        load_config(CODE_W'($urandom), 5'd0, CODE_W'($urandom), 5'd31,
                    CODE_W'($urandom), 5'd17);
        sender_idle_en = 1'b0;
        run_random_phase(PHASE_ITEMS);
        wait_for_drain();

        // Last stretch at full rate on both sides.
        load_config(CODE_W'($urandom), LEN_W'($urandom_range(1, 16)),
                    CODE_W'($urandom), LEN_W'($urandom_range(1, 16)),
                    CODE_W'($urandom), LEN_W'($urandom_range(1, 16)));
        receiver_idle_en = 1'b0;
        run_random_phase(PHASE_ITEMS);
        wait_for_drain();

        if (fail_count == 0 && pending_bytes == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
